/* design/mtps_pkg.sv */
package mtps_pkg;

    localparam int WINDOW_LEN_DEF = 128;
    localparam int MAX_TAPERS_DEF = 8;

    localparam logic [1:0] LEN_EXACT     = 2'd0;
    localparam logic [1:0] LEN_PADDED    = 2'd1;
    localparam logic [1:0] LEN_TRUNCATED = 2'd2;

    localparam logic CMD_TAPER  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [2:0]         taper_index;
        logic [6:0]         sample_index;
        logic signed [15:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  bin_index;
        logic [49:0] power;
        logic [1:0]  length_status;
        logic        last_bin;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAPER,
        ST_MAC,
        ST_RND,
        ST_SQRE,
        ST_SQIM,
        ST_ACC,
        ST_ORD,
        ST_OLOAD,
        ST_DIV,
        ST_OSEND
    } state_t;

    // round(32768 * sin(pi*j/64)), quarter wave
    localparam logic signed [16:0] SINQ [33] = '{
        17'sd0,     17'sd1608,  17'sd3212,  17'sd4808,  17'sd6393,  17'sd7962,
        17'sd9512,  17'sd11039, 17'sd12539, 17'sd14010, 17'sd15446, 17'sd16846,
        17'sd18204, 17'sd19519, 17'sd20787, 17'sd22005, 17'sd23170, 17'sd24279,
        17'sd25330, 17'sd26320, 17'sd27246, 17'sd28106, 17'sd28899, 17'sd29622,
        17'sd30274, 17'sd30853, 17'sd31357, 17'sd31786, 17'sd32138, 17'sd32413,
        17'sd32610, 17'sd32729, 17'sd32768
    };

    function automatic logic signed [16:0] sin_point(input logic [6:0] i);
        logic [5:0]         r;
        logic signed [16:0] v;
        r = {1'b0, i[4:0]};
        v = i[5] ? SINQ[6'd32 - r] : SINQ[r];
        return i[6] ? -v : v;
    endfunction

    // linear interpolation between circle points, rounding half up
    function automatic logic signed [16:0] lerp_point(input logic [6:0] i,
                                                      input logic [7:0] f);
        logic signed [27:0] a;
        logic signed [27:0] b;
        logic signed [27:0] fs;
        logic signed [27:0] acc;
        a   = sin_point(i);
        b   = sin_point(i + 7'd1);
        fs  = $signed({20'd0, f});
        acc = (a <<< 8) + (b - a) * fs + 28'sd128;
        acc = acc >>> 8;
        return acc[16:0];
    endfunction

endpackage

/* design/mtps_ram.sv */
module mtps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/multitaper_power_spectrum.sv */
// Multitaper power spectrum.
// Input channel (item_valid / item_stall / item): a request with cmd = taper
// writes one coefficient into the taper store; cmd = sample appends one data
// sample to the window. A sample with last set closes the window and starts
// the spectrum; samples past the window length are dropped.
// Output channel (bin_valid / bin_stall / bin): one request per bin, bins
// 0 .. WINDOW_LEN/2-1 in order, last_bin set on the final one.
// cfg_we / cfg_data write the taper count, taken at the next window close.
// Coefficient writes and non-final samples are taken while the block is idle.
// A window is computed as a direct DFT on one shared complex multiply-accumulate,
// then each bin passes a serial divide by the taper count; item_stall is high
// from the window close until the last bin is loaded into the output register.
// The last bin waits in the output register while new requests
// are already taken. A stalled bin holds, and the sequencer holds with it.
// Reset sets the taper count to 1 and empties the window; taper coefficients
// are undefined until written.
module multitaper_power_spectrum #(
    parameter int WINDOW_LEN = mtps_pkg::WINDOW_LEN_DEF,
    parameter int MAX_TAPERS = mtps_pkg::MAX_TAPERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  mtps_pkg::in_item_t  item,
    output logic                bin_valid,
    input  logic                bin_stall,
    output mtps_pkg::out_item_t bin,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_data
);

    localparam int NW     = $clog2(WINDOW_LEN);
    localparam int NCW    = $clog2(WINDOW_LEN + 1);
    localparam int HALF_N = WINDOW_LEN / 2;
    localparam int KW     = $clog2(HALF_N);
    localparam int TAW    = $clog2(MAX_TAPERS * WINDOW_LEN);
    localparam int Q1     = 32768 / WINDOW_LEN;
    localparam int R1     = 32768 % WINDOW_LEN;

    mtps_pkg::state_t state_reg, state_next;

    logic [3:0]     num_tapers_reg;
    logic [3:0]     ntc_reg;
    logic [3:0]     t_reg;
    logic [8:0]     count_reg;
    logic [NCW-1:0] filled_reg;
    logic [1:0]     status_reg;
    logic [NCW-1:0] n_reg;
    logic [KW-1:0]  k_reg;
    logic           a_vld_reg;
    logic [NW-1:0]  a_idx_reg;
    logic           s1_vld_reg, s1_last_reg;
    logic           s2_vld_reg, s2_last_reg;
    logic [14:0]    q_reg, dq_reg;
    logic [NW-1:0]  r_reg, dr_reg;
    logic [5:0]     div_cnt_reg;
    logic           bin_valid_reg;

    logic signed [16:0] c_reg, s_reg;
    logic signed [32:0] pr_reg, pi_reg;
    logic signed [41:0] sr_reg, si_reg;
    logic signed [23:0] re_reg, im_reg;
    logic [47:0]        sq_re_reg, sq_im_reg;
    logic [51:0]        div_reg;
    logic [2:0]         rem_reg;
    mtps_pkg::out_item_t bin_reg;

    // memories
    logic                tap_we;
    logic [TAW-1:0]      tap_waddr, tap_raddr;
    logic [15:0]         tap_rdata;
    logic                smp_we;
    logic [NW-1:0]       smp_waddr;
    logic [15:0]         smp_rdata;
    logic                tw_we;
    logic [15:0]         tw_wdata, tw_rdata;
    logic                acc_we;
    logic [51:0]         acc_wdata, acc_rdata;

    logic        accept;
    logic [8:0]  count_inc;
    logic        out_free;

    logic signed [31:0] tp_prod;
    logic signed [31:0] tp_rnd;
    logic signed [15:0] smp_sel;

    logic [NW:0]   r_sum;
    logic [NW:0]   dr_sum;
    logic [48:0]   pw;
    logic [52:0]   acc_sum;
    logic [3:0]    rem_sh;
    logic signed [41:0] sr_rnd, si_rnd;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != mtps_pkg::ST_IDLE);
    assign count_inc  = (count_reg < 9'd511) ? count_reg + 9'd1 : count_reg;
    assign out_free   = !bin_valid_reg || !bin_stall;
    assign bin_valid  = bin_valid_reg;
    assign bin        = bin_reg;

    assign tap_we    = accept && (item.cmd == mtps_pkg::CMD_TAPER)
                       && ({1'b0, item.taper_index} < 4'(MAX_TAPERS))
                       && ({1'b0, item.sample_index} < 8'(WINDOW_LEN));
    assign tap_waddr = TAW'(item.taper_index) * TAW'(WINDOW_LEN) + TAW'(item.sample_index);
    assign tap_raddr = TAW'(t_reg) * TAW'(WINDOW_LEN) + TAW'(n_reg);

    assign smp_we    = accept && (item.cmd == mtps_pkg::CMD_SAMPLE)
                       && (count_reg < 9'(WINDOW_LEN));
    assign smp_waddr = count_reg[NW-1:0];

    // taper product; padded positions read as zero
    assign smp_sel  = (NCW'(a_idx_reg) < filled_reg) ? $signed(smp_rdata) : 16'sd0;
    assign tp_prod  = $signed(tap_rdata) * smp_sel;
    assign tp_rnd   = (tp_prod + 32'sd16384) >>> 15;
    assign tw_we    = (state_reg == mtps_pkg::ST_TAPER) && a_vld_reg;
    assign tw_wdata = (tp_rnd > 32'sd32767) ? 16'h7FFF : tp_rnd[15:0];

    assign r_sum  = {1'b0, r_reg} + {1'b0, dr_reg};
    assign dr_sum = {1'b0, dr_reg} + (NW+1)'(R1);

    assign sr_rnd  = (sr_reg + 42'sd16384) >>> 15;
    assign si_rnd  = (si_reg + 42'sd16384) >>> 15;
    assign pw      = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign acc_sum = {1'b0, acc_rdata} + 53'(pw);
    assign acc_we  = (state_reg == mtps_pkg::ST_ACC);
    assign acc_wdata = (t_reg == 4'd0) ? 52'(pw)
                     : (acc_sum[52] ? {52{1'b1}} : acc_sum[51:0]);

    assign rem_sh = {rem_reg, div_reg[51]};

    mtps_ram #(.WIDTH(16), .DEPTH(MAX_TAPERS * WINDOW_LEN)) u_taper_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (item.value),
        .raddr (tap_raddr),
        .rdata (tap_rdata)
    );

    mtps_ram #(.WIDTH(16), .DEPTH(WINDOW_LEN)) u_sample_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (item.value),
        .raddr (n_reg[NW-1:0]),
        .rdata (smp_rdata)
    );

    mtps_ram #(.WIDTH(16), .DEPTH(WINDOW_LEN)) u_tapered_ram (
        .clk   (clk),
        .we    (tw_we),
        .waddr (a_idx_reg),
        .wdata (tw_wdata),
        .raddr (n_reg[NW-1:0]),
        .rdata (tw_rdata)
    );

    mtps_ram #(.WIDTH(52), .DEPTH(HALF_N)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (k_reg),
        .wdata (acc_wdata),
        .raddr (k_reg),
        .rdata (acc_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtps_pkg::ST_IDLE:
            begin
                if (accept && item.cmd == mtps_pkg::CMD_SAMPLE && item.last)
                begin
                    state_next = mtps_pkg::ST_TAPER;
                end
            end
            mtps_pkg::ST_TAPER:
            begin
                if (a_vld_reg && a_idx_reg == NW'(WINDOW_LEN - 1))
                begin
                    state_next = mtps_pkg::ST_MAC;
                end
            end
            mtps_pkg::ST_MAC:
            begin
                if (s2_vld_reg && s2_last_reg)
                begin
                    state_next = mtps_pkg::ST_RND;
                end
            end
            mtps_pkg::ST_RND:   state_next = mtps_pkg::ST_SQRE;
            mtps_pkg::ST_SQRE:  state_next = mtps_pkg::ST_SQIM;
            mtps_pkg::ST_SQIM:  state_next = mtps_pkg::ST_ACC;
            mtps_pkg::ST_ACC:
            begin
                if (k_reg != KW'(HALF_N - 1))
                begin
                    state_next = mtps_pkg::ST_MAC;
                end
                else if (t_reg + 4'd1 == ntc_reg)
                begin
                    state_next = mtps_pkg::ST_ORD;
                end
                else
                begin
                    state_next = mtps_pkg::ST_TAPER;
                end
            end
            mtps_pkg::ST_ORD:   state_next = mtps_pkg::ST_OLOAD;
            mtps_pkg::ST_OLOAD: state_next = mtps_pkg::ST_DIV;
            mtps_pkg::ST_DIV:
            begin
                if (div_cnt_reg == 6'd51)
                begin
                    state_next = mtps_pkg::ST_OSEND;
                end
            end
            mtps_pkg::ST_OSEND:
            begin
                if (out_free)
                begin
                    state_next = (k_reg == KW'(HALF_N - 1)) ? mtps_pkg::ST_IDLE
                                                           : mtps_pkg::ST_ORD;
                end
            end
            default:            state_next = mtps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mtps_pkg::ST_IDLE;
            num_tapers_reg <= 4'd1;
            ntc_reg        <= 4'd1;
            t_reg          <= '0;
            count_reg      <= '0;
            filled_reg     <= '0;
            status_reg     <= mtps_pkg::LEN_EXACT;
            n_reg          <= '0;
            k_reg          <= '0;
            a_vld_reg      <= 1'b0;
            a_idx_reg      <= '0;
            s1_vld_reg     <= 1'b0;
            s1_last_reg    <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s2_last_reg    <= 1'b0;
            q_reg          <= '0;
            dq_reg         <= '0;
            r_reg          <= '0;
            dr_reg         <= '0;
            div_cnt_reg    <= '0;
            bin_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                num_tapers_reg <= cfg_data;
            end
            if (bin_valid_reg && !bin_stall)
            begin
                bin_valid_reg <= 1'b0;
            end
            case (state_reg)
                mtps_pkg::ST_IDLE:
                begin
                    if (accept && item.cmd == mtps_pkg::CMD_SAMPLE)
                    begin
                        count_reg <= count_inc;
                        if (item.last)
                        begin
                            if (count_inc < 9'(WINDOW_LEN))
                            begin
                                status_reg <= mtps_pkg::LEN_PADDED;
                                filled_reg <= NCW'(count_inc);
                            end
                            else
                            begin
                                status_reg <= (count_inc > 9'(WINDOW_LEN))
                                              ? mtps_pkg::LEN_TRUNCATED
                                              : mtps_pkg::LEN_EXACT;
                                filled_reg <= NCW'(WINDOW_LEN);
                            end
                            if (num_tapers_reg == 4'd0)
                            begin
                                ntc_reg <= 4'd1;
                            end
                            else if (num_tapers_reg > 4'(MAX_TAPERS))
                            begin
                                ntc_reg <= 4'(MAX_TAPERS);
                            end
                            else
                            begin
                                ntc_reg <= num_tapers_reg;
                            end
                            t_reg     <= '0;
                            k_reg     <= '0;
                            n_reg     <= '0;
                            dq_reg    <= '0;
                            dr_reg    <= '0;
                            a_vld_reg <= 1'b0;
                        end
                    end
                end
                mtps_pkg::ST_TAPER:
                begin
                    a_vld_reg <= (n_reg < NCW'(WINDOW_LEN));
                    a_idx_reg <= n_reg[NW-1:0];
                    if (n_reg < NCW'(WINDOW_LEN))
                    begin
                        n_reg <= n_reg + 1'b1;
                    end
                    if (a_vld_reg && a_idx_reg == NW'(WINDOW_LEN - 1))
                    begin
                        a_vld_reg  <= 1'b0;
                        n_reg      <= '0;
                        q_reg      <= '0;
                        r_reg      <= NW'(HALF_N);
                        s1_vld_reg <= 1'b0;
                        s2_vld_reg <= 1'b0;
                    end
                end
                mtps_pkg::ST_MAC:
                begin
                    s1_vld_reg  <= (n_reg < NCW'(WINDOW_LEN));
                    s1_last_reg <= (n_reg == NCW'(WINDOW_LEN - 1));
                    s2_vld_reg  <= s1_vld_reg;
                    s2_last_reg <= s1_last_reg;
                    if (n_reg < NCW'(WINDOW_LEN))
                    begin
                        n_reg <= n_reg + 1'b1;
                        // advance the phase by k/N turn
                        if (r_sum >= (NW+1)'(WINDOW_LEN))
                        begin
                            r_reg <= NW'(r_sum - (NW+1)'(WINDOW_LEN));
                            q_reg <= q_reg + dq_reg + 15'd1;
                        end
                        else
                        begin
                            r_reg <= r_sum[NW-1:0];
                            q_reg <= q_reg + dq_reg;
                        end
                    end
                end
                mtps_pkg::ST_ACC:
                begin
                    n_reg      <= '0;
                    q_reg      <= '0;
                    r_reg      <= NW'(HALF_N);
                    s1_vld_reg <= 1'b0;
                    s2_vld_reg <= 1'b0;
                    if (k_reg != KW'(HALF_N - 1))
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (dr_sum >= (NW+1)'(WINDOW_LEN))
                        begin
                            dr_reg <= NW'(dr_sum - (NW+1)'(WINDOW_LEN));
                            dq_reg <= dq_reg + 15'(Q1 + 1);
                        end
                        else
                        begin
                            dr_reg <= dr_sum[NW-1:0];
                            dq_reg <= dq_reg + 15'(Q1);
                        end
                    end
                    else
                    begin
                        k_reg  <= '0;
                        dq_reg <= '0;
                        dr_reg <= '0;
                        if (t_reg + 4'd1 != ntc_reg)
                        begin
                            t_reg <= t_reg + 4'd1;
                        end
                    end
                end
                mtps_pkg::ST_OLOAD:
                begin
                    div_cnt_reg <= '0;
                end
                mtps_pkg::ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                end
                mtps_pkg::ST_OSEND:
                begin
                    if (out_free)
                    begin
                        bin_valid_reg <= 1'b1;
                        if (k_reg == KW'(HALF_N - 1))
                        begin
                            k_reg     <= '0;
                            count_reg <= '0;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mtps_pkg::ST_TAPER:
            begin
                sr_reg <= '0;
                si_reg <= '0;
            end
            mtps_pkg::ST_MAC:
            begin
                c_reg  <= mtps_pkg::lerp_point(q_reg[14:8] + 7'd32, q_reg[7:0]);
                s_reg  <= mtps_pkg::lerp_point(q_reg[14:8], q_reg[7:0]);
                pr_reg <= $signed(tw_rdata) * c_reg;
                pi_reg <= $signed(tw_rdata) * s_reg;
                if (s2_vld_reg)
                begin
                    sr_reg <= sr_reg + 42'(pr_reg);
                    si_reg <= si_reg - 42'(pi_reg);
                end
            end
            mtps_pkg::ST_RND:
            begin
                re_reg <= sr_rnd[23:0];
                im_reg <= si_rnd[23:0];
            end
            mtps_pkg::ST_SQRE:
            begin
                sq_re_reg <= re_reg * re_reg;
            end
            mtps_pkg::ST_SQIM:
            begin
                sq_im_reg <= im_reg * im_reg;
            end
            mtps_pkg::ST_ACC:
            begin
                sr_reg <= '0;
                si_reg <= '0;
            end
            mtps_pkg::ST_OLOAD:
            begin
                div_reg <= acc_rdata;
                rem_reg <= '0;
            end
            mtps_pkg::ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (rem_sh >= ntc_reg)
                begin
                    rem_reg <= 3'(rem_sh - ntc_reg);
                    div_reg <= {div_reg[50:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[2:0];
                    div_reg <= {div_reg[50:0], 1'b0};
                end
            end
            mtps_pkg::ST_OSEND:
            begin
                if (out_free)
                begin
                    bin_reg.bin_index     <= 6'(k_reg);
                    bin_reg.power         <= (div_reg[51:50] != 2'd0) ? {50{1'b1}}
                                                                      : div_reg[49:0];
                    bin_reg.length_status <= status_reg;
                    bin_reg.last_bin      <= (k_reg == KW'(HALF_N - 1));
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
